[rtl/core/lz78_token_decoder_defines.svh]
// assertion macros for the lz78 token decoder checker
`ifndef LZ78_TOKEN_DECODER_DEFINES_SVH
`define LZ78_TOKEN_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LZTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LZTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lz78td_pkg.sv]
// shared constants and types of the lz78 token decoder
package lz78td_pkg;

    localparam int DICT_DEPTH_DEF = 4096;
    localparam int MAX_PHRASE_DEF = 64;
    localparam int BYTE_W         = 8;
    localparam int IDX_IN_W       = 16;
    localparam int STATUS_W       = 2;
    localparam int S_DATA_W       = 24;
    localparam int M_DATA_W       = 8;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_UNDEF    = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_TOO_LONG = 2'd3
    } status_t;

endpackage

[rtl/core/lz78_token_decoder.sv]
// lz78 token decoder: dictionary walk and byte emission
//
// s_* channel carries one token per transaction: the prefix index and the
// literal byte in s_tdata, the end-of-message mark in s_tlast.
// m_* channel carries one decoded byte per transaction in m_tdata, with
// m_tlast on the last byte of the token's phrase and the status in m_tuser.
// a token is decoded in steps: one dictionary read per prefix byte while
// the parent chain is walked into the phrase stack, then the new entry is
// added, then the prefix bytes from the phrase stack and the literal are
// emitted, one byte per cycle while the output register is not stalled,
// and the decoder returns to idle to take the next token. the single
// dictionary read port and the chain walk bound the decode time.
// a new token is accepted once the last byte of the previous one is held in
// the output register, so the two overlap by one transaction.
// reset empties the dictionary at once (entry count back to one), no sweep.
// when the receiver stalls, the output register holds its byte and emission
// pauses; no byte is dropped or repeated.
module lz78_token_decoder #(
    parameter int DICT_DEPTH = lz78td_pkg::DICT_DEPTH_DEF,
    parameter int MAX_PHRASE = lz78td_pkg::MAX_PHRASE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lz78td_pkg::S_DATA_W-1:0]   s_tdata,  // prefix_index, literal_byte
    input  logic                              s_tlast,  // end_of_message
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lz78td_pkg::M_DATA_W-1:0]   m_tdata,  // out_byte
    output logic                              m_tlast,  // phrase_end
    output logic [lz78td_pkg::STATUS_W-1:0]   m_tuser   // status
);
    import lz78td_pkg::*;

    localparam int IDX_W = $clog2(DICT_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = IDX_IN_W + 1;
    localparam int LEN_W = $clog2(MAX_PHRASE + 1);
    localparam int STK_W = $clog2(MAX_PHRASE);
    localparam int ENT_W = IDX_W + BYTE_W + LEN_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_ADD    = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    logic [ENT_W-1:0]  dict_mem [DICT_DEPTH];
    logic [BYTE_W-1:0] stk_mem  [MAX_PHRASE];

    state_t             state_reg, state_next;
    status_t            status_reg, status_next;
    logic               walk_reg, walk_next;
    logic               last_reg, last_next;
    logic [BYTE_W-1:0]  lit_reg, lit_next;
    logic [IDX_W-1:0]   parent_reg, parent_next;
    logic [STK_W-1:0]   plen_reg, plen_next;
    logic [STK_W-1:0]   k_reg, k_next;
    logic [STK_W-1:0]   e_reg, e_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    status_t            out_status_reg, out_status_next;

    logic [ENT_W-1:0]   dict_rd_reg;
    logic [IDX_W-1:0]   dict_raddr;
    logic               dict_we;
    logic [IDX_W-1:0]   dict_waddr;
    logic [ENT_W-1:0]   dict_wdata;
    logic [BYTE_W-1:0]  stk_rd_reg;
    logic               stk_we;
    logic [STK_W-1:0]   stk_waddr;

    logic [IDX_IN_W-1:0] idx_in;
    logic                idx_ok;
    logic [LEN_W-1:0]    rd_len;
    logic [BYTE_W-1:0]   rd_byte;
    logic [IDX_W-1:0]    rd_parent;
    logic                load_out;

    assign idx_in    = s_tdata[IDX_IN_W-1:0];
    assign idx_ok    = (idx_in != '0) && (CMP_W'(idx_in) < CMP_W'(cnt_reg));
    assign rd_len    = dict_rd_reg[LEN_W-1:0];
    assign rd_byte   = dict_rd_reg[LEN_W +: BYTE_W];
    assign rd_parent = dict_rd_reg[LEN_W+BYTE_W +: IDX_W];
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        walk_next       = walk_reg;
        last_next       = last_reg;
        lit_next        = lit_reg;
        parent_next     = parent_reg;
        plen_next       = plen_reg;
        k_next          = k_reg;
        e_next          = e_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        dict_raddr      = rd_parent;
        dict_we         = 1'b0;
        dict_waddr      = cnt_reg[IDX_W-1:0];
        dict_wdata      = {parent_reg, lit_reg, LEN_W'(plen_reg) + LEN_W'(1)};
        stk_we          = 1'b0;
        stk_waddr       = k_reg - STK_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                dict_raddr = idx_in[IDX_W-1:0];
                if (s_tvalid)
                begin
                    lit_next    = s_tdata[IDX_IN_W +: BYTE_W];
                    last_next   = s_tlast;
                    walk_next   = idx_ok;
                    parent_next = idx_ok ? idx_in[IDX_W-1:0] : '0;
                    plen_next   = '0;
                    status_next = (idx_in != '0 && !idx_ok) ? STATUS_UNDEF : STATUS_OK;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!walk_reg)
                begin
                    state_next = ST_ADD;
                end
                else if (rd_len >= LEN_W'(MAX_PHRASE))
                begin
                    status_next = STATUS_TOO_LONG;
                    parent_next = '0;
                    state_next  = ST_ADD;
                end
                else
                begin
                    plen_next = rd_len[STK_W-1:0];
                    stk_we    = 1'b1;
                    stk_waddr = rd_len[STK_W-1:0] - STK_W'(1);
                    k_next    = rd_len[STK_W-1:0] - STK_W'(1);
                    state_next = (rd_len == LEN_W'(1)) ? ST_ADD : ST_WALK;
                end
            end
            ST_WALK:
            begin
                stk_we = 1'b1;
                k_next = k_reg - STK_W'(1);
                if (k_reg == STK_W'(1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (cnt_reg < CNT_W'(DICT_DEPTH))
                begin
                    dict_we  = 1'b1;
                    cnt_next = last_reg ? CNT_W'(1) : cnt_reg + CNT_W'(1);
                end
                else
                begin
                    if (status_reg != STATUS_TOO_LONG)
                    begin
                        status_next = STATUS_FULL;
                    end
                    cnt_next = last_reg ? CNT_W'(1) : cnt_reg;
                end
                e_next     = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = (e_reg < plen_reg) ? stk_rd_reg : lit_reg;
                    out_last_next   = (e_reg == plen_reg);
                    out_status_next = status_reg;
                    e_next          = e_reg + STK_W'(1);
                    if (e_reg == plen_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // dictionary: parent, byte, length per entry
    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[dict_waddr] <= dict_wdata;
        end
        dict_rd_reg <= dict_mem[dict_raddr];
    end

    // phrase stack, read one ahead of emission
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= rd_byte;
        end
        stk_rd_reg <= stk_mem[e_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        walk_reg       <= walk_next;
        last_reg       <= last_next;
        lit_reg        <= lit_next;
        parent_reg     <= parent_next;
        plen_reg       <= plen_next;
        k_reg          <= k_next;
        e_reg          <= e_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

endmodule

[rtl/core/lz78td_checker.sv]
// port-level checker of the lz78 token decoder and its bind
`include "lz78_token_decoder_defines.svh"

module lz78td_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [lz78td_pkg::S_DATA_W-1:0]   s_tdata,  // prefix_index, literal_byte
    input logic                              s_tlast,  // end_of_message
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lz78td_pkg::M_DATA_W-1:0]   m_tdata,  // out_byte
    input logic                              m_tlast,  // phrase_end
    input logic [lz78td_pkg::STATUS_W-1:0]   m_tuser   // status
);
    import lz78td_pkg::*;

    logic out_stall;
    logic in_pending;

    assign out_stall  = m_tvalid && !m_tready;
    assign in_pending = s_tvalid && s_tready && (s_tdata != '0) && s_tlast;

    // a stalled transaction keeps its byte, flag and status
    `LZTD_ASSERT_NEXT(a_out_hold, out_stall,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "output changed while stalled")

    // a too-long prefix yields the literal alone
    `LZTD_ASSERT_NOW(a_too_long_single, m_tvalid && m_tuser == STATUS_TOO_LONG,
        m_tlast, "too-long token emitted more than one byte")

    // an undefined index is an empty prefix
    `LZTD_ASSERT_NOW(a_undef_single, m_tvalid && m_tuser == STATUS_UNDEF,
        m_tlast, "undefined-index token emitted more than one byte")

    // no new token while a phrase is still being emitted
    `LZTD_ASSERT_NOW(a_no_overlap, (m_tvalid && !m_tlast) || in_pending,
        !(m_tvalid && !m_tlast) || !s_tready, "token accepted mid-phrase")

endmodule

bind lz78_token_decoder lz78td_checker u_lz78td_checker (.*);

[tb/tb_top.sv]
// self-checking testbench of the lz78 token decoder with its own dictionary model
`timescale 1ns / 100ps

module tb_top;
    import lz78td_pkg::*;

    localparam int DEPTH      = DICT_DEPTH_DEF;
    localparam int PHRASE_MAX = MAX_PHRASE_DEF;
    localparam int LIMIT      = 10000000;
    localparam int TAIL       = 4 * PHRASE_MAX + 40;
    localparam int RAND_ITEMS = 432;

    typedef struct {
        bit [IDX_IN_W-1:0] idx;
        bit [BYTE_W-1:0]   lit;
        bit                eom;
    } token_t;

    typedef struct {
        bit [BYTE_W-1:0] data;
        bit              last;
        status_t         st;
    } out_byte_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic [STATUS_W-1:0] m_tuser;

    bit [11:0]       dict_parent [DEPTH];
    bit [BYTE_W-1:0] dict_byte   [DEPTH];
    bit [6:0]        dict_len    [DEPTH];
    int              dict_count = 1;

    token_t    tokens_to_send [$];
    out_byte_t bytes_awaited  [$];
    token_t    drv_tok;
    out_byte_t got_exp;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  mismatches     = 0;
    int  cycle_cnt      = 0;
    int  gen_count      = 1;
    int  too_long_idx;
    int  pick;

    lz78_token_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // expected bytes of one token, dictionary updated afterwards
    function automatic void decode_token(bit [IDX_IN_W-1:0] idx, bit [BYTE_W-1:0] lit,
                                         bit eom);
        status_t         st;
        int              plen;
        int              p;
        int              k;
        bit [11:0]       par;
        bit [BYTE_W-1:0] stack [PHRASE_MAX];
        out_byte_t       ob;
        st   = STATUS_OK;
        plen = 0;
        par  = '0;
        if (idx != 0)
        begin
            if (idx >= dict_count || idx >= DEPTH)
                st = STATUS_UNDEF;
            else if (dict_len[idx] >= PHRASE_MAX)
                st = STATUS_TOO_LONG;
            else
            begin
                plen = dict_len[idx];
                par  = idx[11:0];
                p    = idx;
                for (k = plen; k > 0; k--)
                begin
                    stack[k-1] = dict_byte[p];
                    p = dict_parent[p];
                end
            end
        end
        if (dict_count >= DEPTH)
        begin
            if (st < STATUS_FULL)
                st = STATUS_FULL;
        end
        else
        begin
            dict_parent[dict_count] = par;
            dict_byte[dict_count]   = lit;
            dict_len[dict_count]    = 7'(plen + 1);
            dict_count++;
        end
        for (k = 0; k <= plen; k++)
        begin
            ob.data = (k < plen) ? stack[k] : lit;
            ob.last = (k == plen);
            ob.st   = st;
            bytes_awaited.push_back(ob);
        end
        if (eom)
            dict_count = 1;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_token(s_tdata[15:0], s_tdata[23:16], s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (tokens_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_tok = tokens_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {drv_tok.lit, drv_tok.idx};
                    s_tlast  <= drv_tok.eom;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (bytes_awaited.size() == 0)
                begin
                    $display("%0t unexpected: expected none, actual %02h last %0b status %0d",
                             $time, m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end
                else
                begin
                    got_exp = bytes_awaited.pop_front();
                    if (m_tdata !== got_exp.data)
                    begin
                        $display("%0t out_byte: expected %02h, actual %02h",
                                 $time, got_exp.data, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== got_exp.last)
                    begin
                        $display("%0t phrase_end: expected %0b, actual %0b",
                                 $time, got_exp.last, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== got_exp.st)
                    begin
                        $display("%0t status: expected %0d, actual %0d",
                                 $time, got_exp.st, m_tuser);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT)
        begin
            $display("lz78_token_decoder verification failed");
            $finish;
        end
    end

    task automatic push_token(int idx, int lit, bit eom);
        token_t t;
        t.idx = idx[15:0];
        t.lit = lit[7:0];
        t.eom = eom;
        tokens_to_send.push_back(t);
        if (gen_count < DEPTH)
            gen_count++;
        if (eom)
            gen_count = 1;
    endtask

    // sampled away from the rising edge so the driver and monitor have settled
    task automatic drain();
        while (tokens_to_send.size() != 0 || s_tvalid || bytes_awaited.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_tokens(int count, int idle, int stall);
        int i;
        int idx;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                idx = gen_count - 1;
            else if (pick < 80)
                idx = $urandom_range(gen_count - 1, 0);
            else if (pick < 92)
                idx = $urandom_range(65535, gen_count);
            else
                idx = 0;
            push_token(idx, $urandom_range(255), $urandom_range(99) < 3);
        end
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, zero bytes inside phrases, undefined indexes, end of message
        push_token(0, 8'h00, 1'b0);
        push_token(0, 8'hff, 1'b0);
        push_token(1, 8'ha5, 1'b0);
        push_token(3, 8'h00, 1'b0);
        push_token(4, 8'h5a, 1'b0);
        push_token(gen_count, 8'h3c, 1'b0);
        push_token(16'hffff, 8'h01, 1'b0);
        push_token(DEPTH, 8'h80, 1'b0);
        push_token(16'h8000, 8'h7f, 1'b0);
        push_token(5, 8'hc3, 1'b1);
        push_token(1, 8'h11, 1'b0);
        push_token(0, 8'h22, 1'b0);
        push_token(1, 8'h33, 1'b0);
        push_token(16'h5555, 8'h55, 1'b0);
        push_token(16'haaaa, 8'haa, 1'b1);
        drain();

        random_tokens(RAND_ITEMS / 4, 0, 0);
        random_tokens(RAND_ITEMS / 4, 45, 0);
        random_tokens(RAND_ITEMS / 4, 0, 45);
        random_tokens(RAND_ITEMS / 4, 18, 18);

        // longest phrase, then a prefix that is too long
        send_idle_pct  = 0;
        recv_stall_pct = 18;
        push_token(0, $urandom_range(255), 1'b1);
        push_token(0, $urandom_range(255), 1'b0);
        repeat (PHRASE_MAX - 1)
            push_token(gen_count - 1, $urandom_range(255), 1'b0);
        too_long_idx = gen_count - 1;
        push_token(too_long_idx, $urandom_range(255), 1'b0);
        drain();

        // fill the dictionary
        while (gen_count < DEPTH)
            push_token(($urandom_range(99) < 90) ? 0 : $urandom_range(gen_count - 1, 0),
                       $urandom_range(255), 1'b0);
        drain();

        // dictionary full, alone and together with the other conditions
        send_idle_pct  = 45;
        recv_stall_pct = 45;
        push_token(0, 8'h00, 1'b0);
        push_token(DEPTH, 8'hff, 1'b0);
        push_token(16'hffff, 8'h01, 1'b0);
        push_token(DEPTH - 1, 8'h02, 1'b0);
        push_token(2, 8'h03, 1'b0);
        push_token(too_long_idx, 8'h04, 1'b0);
        push_token(too_long_idx - 1, 8'h05, 1'b1);
        push_token(5, 8'h06, 1'b0);
        push_token(1, 8'h07, 1'b0);
        push_token(0, 8'h08, 1'b0);
        drain();

        repeat (TAIL) @(posedge clk);
        if (mismatches == 0 && bytes_awaited.size() == 0)
            $display("lz78_token_decoder verification clean");
        else
            $display("lz78_token_decoder verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lz78td_pkg.sv
rtl/core/lz78_token_decoder.sv
rtl/core/lz78td_checker.sv
tb/tb_top.sv
